FILE: rtl/jd2cal_pkg.sv
// ----------------------------------------------------------------------------
// jd2cal_pkg: constants and tables for the day number to date converter
// Field widths, calendar constants, and the reciprocal multipliers
// that replace the constant divisions in the datapath.
// ----------------------------------------------------------------------------
package jd2cal_pkg;

   // field widths
   localparam int DAY_W   = 24;
   localparam int YEAR_W  = 17;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int WDAY_W  = 3;

   // internal widths
   localparam int PROD_W  = 31;   // 100 * day number plus bias
   localparam int CENT_W  = 9;    // century count
   localparam int CDAY_W  = 25;   // shifted day count
   localparam int YRS_W   = 16;   // years since the epoch base
   localparam int DIFF_W  = 9;    // days into the March-based year
   localparam int MSEQ_W  = 4;    // March-based month sequence
   localparam int WSUM_W  = 6;    // octal digit sum for the weekday

   // calendar constants
   localparam int GREG_START     = 2299161;
   localparam int AD_START       = 1721424;
   localparam int CENT_OFFSET    = 3204500;
   localparam int BASE_SHIFT     = 1486;
   localparam int JULIAN_FIX     = 38;
   localparam int YEAR_OFFSET100 = 12210;
   localparam int YEAR_DAYS100   = 36525;
   localparam int YEAR_BASE      = 4715;
   localparam int MONTH_JAN      = 1;
   localparam int MONTH_DEC      = 12;
   localparam int MONTH_FEB      = 2;
   localparam int DAY_LAST_DEC   = 31;
   localparam int DAYS_WEEK      = 7;

   // Exact reciprocals: floor(x / D) == (x * ceil(2^S / D)) >> S for x < 2^N
   // when S = N + ceil(log2(D)).
   localparam longint CENT_DIV   = 3652425;
   localparam int     CENT_SHIFT = 53;     // N = 31
   localparam logic [31:0] CENT_MUL =
      32'(((longint'(1) << CENT_SHIFT) + CENT_DIV - 1) / CENT_DIV);

   localparam longint YRS_DIV    = 36525;
   localparam int     YRS_SHIFT  = 47;     // N = 31
   localparam logic [31:0] YRS_MUL =
      32'(((longint'(1) << YRS_SHIFT) + YRS_DIV - 1) / YRS_DIV);

   localparam longint WHOLE_DIV   = 100;
   localparam int     WHOLE_SHIFT = 38;    // N = 31
   localparam logic [31:0] WHOLE_MUL =
      32'(((longint'(1) << WHOLE_SHIFT) + WHOLE_DIV - 1) / WHOLE_DIV);

   // month step 30.61 days; the factor 100 on the dividend is folded in
   localparam longint MONTH_DIV   = 3061;
   localparam int     MSEQ_SHIFT  = 28;    // N = 16
   localparam logic [23:0] MSEQ_MUL =
      24'(100 * (((longint'(1) << MSEQ_SHIFT) + MONTH_DIV - 1) / MONTH_DIV));

   // floor(30.6 * m): first day offset of March-based month m
   function automatic logic [DIFF_W-1:0] month_offset(input logic [MSEQ_W-1:0] mseq);
      logic [DIFF_W-1:0] off;
      case (mseq)
         4'd0:  off = 9'd0;
         4'd1:  off = 9'd30;
         4'd2:  off = 9'd61;
         4'd3:  off = 9'd91;
         4'd4:  off = 9'd122;
         4'd5:  off = 9'd153;
         4'd6:  off = 9'd183;
         4'd7:  off = 9'd214;
         4'd8:  off = 9'd244;
         4'd9:  off = 9'd275;
         4'd10: off = 9'd306;
         4'd11: off = 9'd336;
         4'd12: off = 9'd367;
         4'd13: off = 9'd397;
         4'd14: off = 9'd428;
         default: off = 9'd459;
      endcase
      return off;
   endfunction

endpackage

FILE: rtl/julian_day_to_calendar_date.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date: Julian day number to calendar date
// Eleven-stage pipeline converting an integer day number into year, month,
// day, weekday, BC flag and first/last-day-of-year flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one day number per beat, valid/ready.
//   rsp_*  : one date per beat, valid/ready; the last pipeline stage is the
//            output register.
//   A request beat passes through 11 register stages to rsp_valid; the first
//   stage loads at the edge that accepts the beat. Throughput is one beat per
//   cycle while rsp_ready is high; the datapath is a chain of constant
//   multipliers (reciprocal divides) spread over the stages, no feedback.
//   Each stage has its own valid bit and loads when it is empty or when the
//   stage after it loads, so bubbles close up while the receiver stalls.
//   With rsp_ready low and all stages full, req_ready drops; nothing is lost
//   or repeated. req_ready is high whenever the output register is empty.
//   Day numbers from 2299161 on use the Gregorian calendar, earlier ones the
//   Julian calendar. BC years come out negative with no year zero.
//   Reset (synchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date import jd2cal_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [DAY_W-1:0]          req_day_number,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [YEAR_W-1:0]  rsp_year_signed,
   output logic [MONTH_W-1:0]        rsp_month_number,
   output logic [DOM_W-1:0]          rsp_day_of_month,
   output logic [WDAY_W-1:0]         rsp_weekday,
   output logic                      rsp_before_christ,
   output logic                      rsp_year_edge
);

   localparam int NUM_STG = 11;
   localparam int LAST    = NUM_STG - 1;

   logic [NUM_STG-1:0] vld_ff, vld_in, stg_en;

   // stage-local ready chain
   always_comb begin
      stg_en[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stg_en[k] = !vld_ff[k] || stg_en[k+1];
      end
      vld_in[0] = stg_en[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         vld_in[k] = stg_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stg_en[0];
   assign rsp_valid = vld_ff[LAST];

   // ---------------- stage 1: scale input, range flags, digit sum ----------
   logic [DAY_W-1:0]  jd1_ff;
   logic [PROD_W-1:0] x1_ff, x1_in;
   logic              greg1_ff, bc1_ff;
   logic [WSUM_W-1:0] wsum1_ff, wsum1_in;
   logic [DAY_W:0]    jd_inc;

   always_comb begin
      x1_in  = PROD_W'(req_day_number) * PROD_W'(100) + PROD_W'(CENT_OFFSET);
      jd_inc = {1'b0, req_day_number} + (DAY_W+1)'(1);
      // 8 == 1 mod 7, so the octal digit sum keeps the residue
      wsum1_in = WSUM_W'(jd_inc[DAY_W]);
      for (int i = 0; i < 8; i++) begin
         wsum1_in = wsum1_in + WSUM_W'(jd_inc[3*i +: 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         jd1_ff   <= req_day_number;
         x1_ff    <= x1_in;
         greg1_ff <= (req_day_number >= DAY_W'(GREG_START));
         bc1_ff   <= (req_day_number < DAY_W'(AD_START));
         wsum1_ff <= wsum1_in;
      end
   end

   // ---------------- stage 2: century count, weekday fold ------------------
   logic [DAY_W-1:0]  jd2_ff;
   logic              greg2_ff, bc2_ff;
   logic [CENT_W-1:0] cent2_ff;
   logic [WDAY_W-1:0] wd2_ff, wd2_in;
   logic [62:0]       cent_prod;
   logic [3:0]        wfold_a, wfold_b;

   always_comb begin
      cent_prod = 63'(x1_ff) * 63'(CENT_MUL);
      wfold_a   = 4'(wsum1_ff[5:3]) + 4'(wsum1_ff[2:0]);
      wfold_b   = 4'(wfold_a[3]) + 4'(wfold_a[2:0]);
      wd2_in    = (wfold_b >= 4'(DAYS_WEEK)) ? 3'(wfold_b - 4'(DAYS_WEEK)) : wfold_b[2:0];
   end

   always_ff @(posedge clock) begin
      if (stg_en[1]) begin
         jd2_ff   <= jd1_ff;
         greg2_ff <= greg1_ff;
         bc2_ff   <= bc1_ff;
         cent2_ff <= cent_prod[CENT_SHIFT +: CENT_W];
         wd2_ff   <= wd2_in;
      end
   end

   // ---------------- stage 3: calendar correction --------------------------
   logic [CDAY_W-1:0] c3_ff, c3_in, corr;
   logic              bc3_ff;
   logic [WDAY_W-1:0] wd3_ff;

   always_comb begin
      corr  = greg2_ff ? (CDAY_W'(cent2_ff) - CDAY_W'(cent2_ff >> 2))
                       : CDAY_W'(JULIAN_FIX);
      c3_in = CDAY_W'(jd2_ff) + CDAY_W'(BASE_SHIFT) + corr;
   end

   always_ff @(posedge clock) begin
      if (stg_en[2]) begin
         c3_ff  <= c3_in;
         bc3_ff <= bc2_ff;
         wd3_ff <= wd2_ff;
      end
   end

   // ---------------- stage 4: year dividend --------------------------------
   logic [CDAY_W-1:0] c4_ff;
   logic [PROD_W-1:0] x2_ff;
   logic              bc4_ff;
   logic [WDAY_W-1:0] wd4_ff;

   always_ff @(posedge clock) begin
      if (stg_en[3]) begin
         c4_ff  <= c3_ff;
         x2_ff  <= PROD_W'(c3_ff) * PROD_W'(100) - PROD_W'(YEAR_OFFSET100);
         bc4_ff <= bc3_ff;
         wd4_ff <= wd3_ff;
      end
   end

   // ---------------- stage 5: year count -----------------------------------
   logic [CDAY_W-1:0] c5_ff;
   logic [YRS_W-1:0]  yrs5_ff;
   logic              bc5_ff;
   logic [WDAY_W-1:0] wd5_ff;
   logic [62:0]       yrs_prod;

   assign yrs_prod = 63'(x2_ff) * 63'(YRS_MUL);

   always_ff @(posedge clock) begin
      if (stg_en[4]) begin
         c5_ff   <= c4_ff;
         yrs5_ff <= yrs_prod[YRS_SHIFT +: YRS_W];
         bc5_ff  <= bc4_ff;
         wd5_ff  <= wd4_ff;
      end
   end

   // ---------------- stage 6: days in whole years, times 100 ---------------
   logic [CDAY_W-1:0] c6_ff;
   logic [YRS_W-1:0]  yrs6_ff;
   logic [PROD_W-1:0] x3_ff;
   logic              bc6_ff;
   logic [WDAY_W-1:0] wd6_ff;

   always_ff @(posedge clock) begin
      if (stg_en[5]) begin
         c6_ff   <= c5_ff;
         yrs6_ff <= yrs5_ff;
         x3_ff   <= PROD_W'(yrs5_ff) * PROD_W'(YEAR_DAYS100);
         bc6_ff  <= bc5_ff;
         wd6_ff  <= wd5_ff;
      end
   end

   // ---------------- stage 7: days in whole years --------------------------
   logic [CDAY_W-1:0] c7_ff, whole7_ff;
   logic [YRS_W-1:0]  yrs7_ff;
   logic              bc7_ff;
   logic [WDAY_W-1:0] wd7_ff;
   logic [62:0]       whole_prod;

   assign whole_prod = 63'(x3_ff) * 63'(WHOLE_MUL);

   always_ff @(posedge clock) begin
      if (stg_en[6]) begin
         c7_ff     <= c6_ff;
         whole7_ff <= whole_prod[WHOLE_SHIFT +: CDAY_W];
         yrs7_ff   <= yrs6_ff;
         bc7_ff    <= bc6_ff;
         wd7_ff    <= wd6_ff;
      end
   end

   // ---------------- stage 8: day within March-based year ------------------
   logic [DIFF_W-1:0] diff8_ff;
   logic [YRS_W-1:0]  yrs8_ff;
   logic              bc8_ff;
   logic [WDAY_W-1:0] wd8_ff;

   always_ff @(posedge clock) begin
      if (stg_en[7]) begin
         diff8_ff <= DIFF_W'(c7_ff - whole7_ff);
         yrs8_ff  <= yrs7_ff;
         bc8_ff   <= bc7_ff;
         wd8_ff   <= wd7_ff;
      end
   end

   // ---------------- stage 9: month sequence -------------------------------
   logic [DIFF_W-1:0] diff9_ff;
   logic [MSEQ_W-1:0] mseq9_ff;
   logic [YRS_W-1:0]  yrs9_ff;
   logic              bc9_ff;
   logic [WDAY_W-1:0] wd9_ff;
   logic [32:0]       mseq_prod;

   assign mseq_prod = 33'(diff8_ff) * 33'(MSEQ_MUL);

   always_ff @(posedge clock) begin
      if (stg_en[8]) begin
         diff9_ff <= diff8_ff;
         mseq9_ff <= mseq_prod[MSEQ_SHIFT +: MSEQ_W];
         yrs9_ff  <= yrs8_ff;
         bc9_ff   <= bc8_ff;
         wd9_ff   <= wd8_ff;
      end
   end

   // ---------------- stage 10: month, day, year ----------------------------
   logic signed [YEAR_W-1:0] yr10_ff, yr10_in;
   logic [MONTH_W-1:0]       mon10_ff, mon10_in;
   logic [DOM_W-1:0]         dom10_ff;
   logic                     bc10_ff;
   logic [WDAY_W-1:0]        wd10_ff;

   always_comb begin
      // sequence 14 and 15 are January and February of the next year
      mon10_in = (mseq9_ff > 4'd13) ? (mseq9_ff - 4'd13) : (mseq9_ff - 4'd1);
      yr10_in  = YEAR_W'(yrs9_ff) - YEAR_W'(YEAR_BASE)
               - YEAR_W'(mon10_in > MONTH_W'(MONTH_FEB)) - YEAR_W'(bc9_ff);
   end

   always_ff @(posedge clock) begin
      if (stg_en[9]) begin
         yr10_ff  <= yr10_in;
         mon10_ff <= mon10_in;
         dom10_ff <= DOM_W'(diff9_ff - month_offset(mseq9_ff));
         bc10_ff  <= bc9_ff;
         wd10_ff  <= wd9_ff;
      end
   end

   // ---------------- stage 11: output register -----------------------------
   logic signed [YEAR_W-1:0] yr11_ff;
   logic [MONTH_W-1:0]       mon11_ff;
   logic [DOM_W-1:0]         dom11_ff;
   logic [WDAY_W-1:0]        wd11_ff;
   logic                     bc11_ff, edge11_ff;

   always_ff @(posedge clock) begin
      if (stg_en[10]) begin
         yr11_ff   <= yr10_ff;
         mon11_ff  <= mon10_ff;
         dom11_ff  <= dom10_ff;
         wd11_ff   <= wd10_ff;
         bc11_ff   <= bc10_ff;
         edge11_ff <= (mon10_ff == MONTH_W'(MONTH_JAN) && dom10_ff == DOM_W'(1))
                   || (mon10_ff == MONTH_W'(MONTH_DEC) && dom10_ff == DOM_W'(DAY_LAST_DEC));
      end
   end

   assign rsp_year_signed   = yr11_ff;
   assign rsp_month_number  = mon11_ff;
   assign rsp_day_of_month  = dom11_ff;
   assign rsp_weekday       = wd11_ff;
   assign rsp_before_christ = bc11_ff;
   assign rsp_year_edge     = edge11_ff;

`ifndef SYNTH
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_number >= 4'd1 && rsp_month_number <= 4'd12))
      else $error("month out of range");

   a_dom_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_day_of_month >= 5'd1))
      else $error("day of month is zero");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= 3'd6))
      else $error("weekday out of range");

   a_bc_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_before_christ == rsp_year_signed[YEAR_W-1]))
      else $error("BC flag disagrees with year sign");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");
`endif

endmodule
